[rtl/sacl_pkg.sv]
// Shared types, constants and helpers for the set-associative tag store.
// No dependencies; every other file of the block except sacl_ram uses this package.
package sacl_pkg;

  localparam int unsigned MaxSets  = 256;
  localparam int unsigned MaxWays  = 8;
  localparam int unsigned SetW     = $clog2(MaxSets);
  localparam int unsigned WayW     = $clog2(MaxWays);
  localparam int unsigned AddrW    = 48;
  localparam int unsigned StampW   = 48;
  localparam int unsigned CoreW    = 3;
  localparam int unsigned CntW     = 32;
  localparam int unsigned NumCnt   = 5;
  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 216;

  typedef enum logic [1:0] {
    FuncAccess  = 2'd0,
    FuncInstall = 2'd1,
    FuncClear   = 2'd2,
    FuncNone    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CfgSetBits = 2'd0,
    CfgWays    = 2'd1,
    CfgMode    = 2'd2,
    CfgUnused  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CntRdAcc  = 3'd0,
    CntWrAcc  = 3'd1,
    CntRdMiss = 3'd2,
    CntWrMiss = 3'd3,
    CntDirtyEv = 3'd4
  } cnt_e;

  typedef enum logic {
    BkIdle = 1'b0,
    BkExec = 1'b1
  } back_state_e;

  // One way of a set as stored in the tag memory
  typedef struct packed {
    logic              valid;
    logic              dirty;
    logic [AddrW-1:0]  tag;
    logic [CoreW-1:0]  owner;
    logic [StampW-1:0] stamp;
  } way_t;

  typedef way_t [MaxWays-1:0] row_t;

  // Classified request handed from the front to the back
  typedef struct packed {
    func_e             func;
    logic              write_op;
    logic [CoreW-1:0]  core;
    logic [StampW-1:0] now;
    logic [SetW-1:0]   set;
    logic [AddrW-1:0]  tag;
    logic [3:0]        bits;
    logic [WayW:0]     nways;
    logic              mode;
  } req_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (&v) ? v : v + CntW'(1);
  endfunction

endpackage

[rtl/sacl_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module sacl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/sacl_front.sv]
// Front end: configuration registers, item intake and set/tag split.
// Depends on sacl_pkg.
module sacl_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [3:0]                    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sacl_pkg::InDataW-1:0]  in_data_i,
  output logic                          push_o,
  output sacl_pkg::req_t                req_o,
  input  logic                          full_i
);

  logic [3:0] set_bits_q, set_bits_d;
  logic [3:0] ways_q, ways_d;
  logic       mode_q, mode_d;

  // Configuration writes
  always_comb begin
    set_bits_d = set_bits_q;
    ways_d     = ways_q;
    mode_d     = mode_q;
    if (cfg_we_i) begin
      unique case (sacl_pkg::cfg_idx_e'(cfg_idx_i))
        sacl_pkg::CfgSetBits: set_bits_d = cfg_data_i;
        sacl_pkg::CfgWays:    ways_d     = cfg_data_i;
        sacl_pkg::CfgMode:    mode_d     = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= 4'd8;
      ways_q     <= 4'd8;
      mode_q     <= 1'b0;
    end else begin
      set_bits_q <= set_bits_d;
      ways_q     <= ways_d;
      mode_q     <= mode_d;
    end
  end

  logic [sacl_pkg::AddrW-1:0] addr;
  logic [sacl_pkg::SetW-1:0]  index_mask;

  // Split the line address into set index and tag
  always_comb begin
    addr = in_data_i[49:2];
    for (int i = 0; i < int'(sacl_pkg::SetW); i++) begin
      index_mask[i] = (5'(i) < {1'b0, set_bits_q});
    end
    req_o.func     = sacl_pkg::func_e'(in_data_i[1:0]);
    req_o.write_op = in_data_i[50];
    req_o.core     = in_data_i[53:51];
    req_o.now      = in_data_i[101:54];
    req_o.set      = addr[sacl_pkg::SetW-1:0] & index_mask;
    req_o.tag      = addr >> set_bits_q;
    req_o.bits     = set_bits_q;
    req_o.mode     = mode_q;
    if (ways_q == 4'd0) begin
      req_o.nways = (sacl_pkg::WayW+1)'(1);
    end else if ({1'b0, ways_q} > 5'(sacl_pkg::MaxWays)) begin
      req_o.nways = (sacl_pkg::WayW+1)'(sacl_pkg::MaxWays);
    end else begin
      req_o.nways = (sacl_pkg::WayW+1)'(ways_q);
    end
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

[rtl/sacl_queue.sv]
// Two-entry request queue between the front and the back.
// Depends on sacl_pkg.
module sacl_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sacl_pkg::req_t req_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output sacl_pkg::req_t req_o
);

  sacl_pkg::req_t slot_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= req_i;
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign req_o   = slot_q[rd_ptr_q];

endmodule

[rtl/sacl_back.sv]
// Back end: set read, hit/victim resolution, write-back, record and counters.
// Depends on sacl_pkg and sacl_ram.
module sacl_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  sacl_pkg::req_t                req_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sacl_pkg::OutDataW-1:0] out_data_o
);

  localparam int unsigned RowW = $bits(sacl_pkg::row_t);

  sacl_pkg::back_state_e state_q, state_d;
  sacl_pkg::req_t        cur_q;
  logic [sacl_pkg::MaxSets-1:0] row_vld_q;
  logic [RowW-1:0]       ram_rdata;
  sacl_pkg::row_t        row, row_new;
  logic                  exec;

  logic                  rec_valid_q, rec_dirty_q;
  logic [sacl_pkg::AddrW-1:0] rec_addr_q;
  logic [sacl_pkg::CoreW-1:0] rec_core_q;
  logic [sacl_pkg::CntW-1:0]  cnt_q [sacl_pkg::NumCnt];
  logic                  rec_valid_d, rec_dirty_d;
  logic [sacl_pkg::AddrW-1:0] rec_addr_d;
  logic [sacl_pkg::CoreW-1:0] rec_core_d;
  logic [sacl_pkg::CntW-1:0]  cnt_d [sacl_pkg::NumCnt];
  logic                  hit, err, write_row;
  logic                  out_valid_q;
  logic [1:0]            flags_q;

  // Sequencer: pop and read in idle, resolve and write in exec
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sacl_pkg::BkIdle: if (pop_o) state_d = sacl_pkg::BkExec;
      sacl_pkg::BkExec: state_d = sacl_pkg::BkIdle;
      default: state_d = sacl_pkg::BkIdle;
    endcase
  end

  always_comb begin
    pop_o = (state_q == sacl_pkg::BkIdle) && !empty_i &&
            (!out_valid_q || out_ready_i);
    exec  = (state_q == sacl_pkg::BkExec);
  end

  sacl_ram #(
    .Width(RowW),
    .Depth(sacl_pkg::MaxSets)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (exec && write_row),
    .waddr_i(cur_q.set),
    .wdata_i(row_new),
    .re_i   (pop_o),
    .raddr_i(req_i.set),
    .rdata_o(ram_rdata)
  );

  // Rows never written read as all zero
  assign row = row_vld_q[cur_q.set] ? sacl_pkg::row_t'(ram_rdata) : '0;

  logic [sacl_pkg::WayW-1:0]   hit_way;
  logic [sacl_pkg::StampW-1:0] l1_st [4];
  logic [sacl_pkg::WayW-1:0]   l1_ix [4];
  logic                        l1_ok [4];
  logic [sacl_pkg::StampW-1:0] l2_st [2];
  logic [sacl_pkg::WayW-1:0]   l2_ix [2];
  logic                        l2_ok [2];
  logic [sacl_pkg::StampW-1:0] l3_st;
  logic [sacl_pkg::WayW-1:0]   l3_ix;
  logic                        l3_ok;
  logic [sacl_pkg::WayW-1:0]   victim;
  logic                        found;
  sacl_pkg::way_t              vw;
  logic [sacl_pkg::AddrW-1:0]  ev_addr;

  // Hit search: first valid way with matching tag and owner
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = sacl_pkg::MaxWays - 1; w >= 0; w--) begin
      if ((4'(w) < cur_q.nways) && row[w].valid && (row[w].tag == cur_q.tag) &&
          (row[w].owner == cur_q.core)) begin
        hit     = 1'b1;
        hit_way = sacl_pkg::WayW'(w);
      end
    end
  end

  // Oldest-way tree, lower way wins ties; mode 1 picks way 0 instead
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if ((4'(2*i) < cur_q.nways) &&
          (!(4'(2*i+1) < cur_q.nways) || row[2*i].stamp <= row[2*i+1].stamp)) begin
        l1_st[i] = row[2*i].stamp;
        l1_ix[i] = sacl_pkg::WayW'(2*i);
        l1_ok[i] = 1'b1;
      end else begin
        l1_st[i] = row[2*i+1].stamp;
        l1_ix[i] = sacl_pkg::WayW'(2*i+1);
        l1_ok[i] = (4'(2*i+1) < cur_q.nways);
      end
    end
    for (int i = 0; i < 2; i++) begin
      if (l1_ok[2*i] && (!l1_ok[2*i+1] || l1_st[2*i] <= l1_st[2*i+1])) begin
        l2_st[i] = l1_st[2*i];
        l2_ix[i] = l1_ix[2*i];
        l2_ok[i] = 1'b1;
      end else begin
        l2_st[i] = l1_st[2*i+1];
        l2_ix[i] = l1_ix[2*i+1];
        l2_ok[i] = l1_ok[2*i+1];
      end
    end
    if (l2_ok[0] && (!l2_ok[1] || l2_st[0] <= l2_st[1])) begin
      l3_st = l2_st[0];
      l3_ix = l2_ix[0];
      l3_ok = 1'b1;
    end else begin
      l3_st = l2_st[1];
      l3_ix = l2_ix[1];
      l3_ok = l2_ok[1];
    end
    if (cur_q.mode) begin
      victim = '0;
      found  = 1'b1;
    end else begin
      victim = l3_ix;
      found  = l3_ok && (l3_st < cur_q.now);
    end
    vw      = row[victim];
    ev_addr = (vw.tag << cur_q.bits) | sacl_pkg::AddrW'(cur_q.set);
  end

  // Row update, record and counters
  always_comb begin
    row_new     = row;
    write_row   = 1'b0;
    err         = 1'b0;
    rec_valid_d = rec_valid_q;
    rec_dirty_d = rec_dirty_q;
    rec_addr_d  = rec_addr_q;
    rec_core_d  = rec_core_q;
    for (int k = 0; k < sacl_pkg::NumCnt; k++) cnt_d[k] = cnt_q[k];
    unique case (cur_q.func)
      sacl_pkg::FuncAccess: begin
        if (hit) begin
          write_row = 1'b1;
          row_new[hit_way].stamp = cur_q.now;
          if (cur_q.write_op) row_new[hit_way].dirty = 1'b1;
        end
        if (cur_q.write_op) begin
          cnt_d[sacl_pkg::CntWrAcc] = sacl_pkg::sat_inc(cnt_q[sacl_pkg::CntWrAcc]);
          if (!hit) cnt_d[sacl_pkg::CntWrMiss] =
              sacl_pkg::sat_inc(cnt_q[sacl_pkg::CntWrMiss]);
        end else begin
          cnt_d[sacl_pkg::CntRdAcc] = sacl_pkg::sat_inc(cnt_q[sacl_pkg::CntRdAcc]);
          if (!hit) cnt_d[sacl_pkg::CntRdMiss] =
              sacl_pkg::sat_inc(cnt_q[sacl_pkg::CntRdMiss]);
        end
      end
      sacl_pkg::FuncInstall: begin
        if (!found) begin
          err = 1'b1;
        end else begin
          write_row = 1'b1;
          if (vw.dirty) cnt_d[sacl_pkg::CntDirtyEv] =
              sacl_pkg::sat_inc(cnt_q[sacl_pkg::CntDirtyEv]);
          rec_valid_d = vw.valid;
          rec_dirty_d = vw.dirty;
          rec_core_d  = vw.owner;
          rec_addr_d  = ev_addr;
          row_new[victim].valid = 1'b1;
          row_new[victim].dirty = cur_q.write_op;
          row_new[victim].tag   = cur_q.tag;
          row_new[victim].owner = cur_q.core;
          row_new[victim].stamp = cur_q.now;
        end
      end
      sacl_pkg::FuncClear: begin
        rec_valid_d = 1'b0;
        rec_dirty_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sacl_pkg::BkIdle;
      row_vld_q   <= '0;
      rec_valid_q <= 1'b0;
      rec_dirty_q <= 1'b0;
      rec_addr_q  <= '0;
      rec_core_q  <= '0;
      for (int k = 0; k < sacl_pkg::NumCnt; k++) cnt_q[k] <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec) begin
        if (write_row) row_vld_q[cur_q.set] <= 1'b1;
        rec_valid_q <= rec_valid_d;
        rec_dirty_q <= rec_dirty_d;
        rec_addr_q  <= rec_addr_d;
        rec_core_q  <= rec_core_d;
        for (int k = 0; k < sacl_pkg::NumCnt; k++) cnt_q[k] <= cnt_d[k];
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers; hit is reported for accesses only
  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= req_i;
    if (exec) flags_q <= {err, hit && (cur_q.func == sacl_pkg::FuncAccess)};
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {1'b0,
                        cnt_q[sacl_pkg::CntDirtyEv], cnt_q[sacl_pkg::CntWrMiss],
                        cnt_q[sacl_pkg::CntRdMiss], cnt_q[sacl_pkg::CntWrAcc],
                        cnt_q[sacl_pkg::CntRdAcc], rec_core_q, rec_addr_q,
                        rec_valid_q && rec_dirty_q, rec_valid_q, flags_q};

endmodule

[rtl/set_assoc_cache_tag_lru.sv]
// Top level of the set-associative tag store with LRU replacement.
// Depends on sacl_pkg, sacl_front, sacl_queue and sacl_back.
//
// Each item (access, install, clear of the eviction record or none) gives
// exactly one result item. The back end reads the whole set from a 256 x 8-way
// tag memory and writes it back in the next cycle, so it takes no new item
// before that write-back; reading and then writing back the same set sets the
// rate. A two-entry queue lets the front take items while the back is busy,
// and the result sits in an output register. Sets never written read as empty
// through per-set valid flops, so no clearing pass follows reset.
module set_assoc_cache_tag_lru (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [3:0]   cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // func[1:0], line_addr[49:2], write_op[50], core_id[53:51], now[101:54]
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit[0], error[1], victim_valid[2], victim_dirty[3], victim_line_addr[51:4],
  // victim_core[54:52], read_accesses[86:55], write_accesses[118:87],
  // read_misses[150:119], write_misses[182:151], dirty_evictions[214:183]
  output logic [215:0] m_axis_tdata
);

  logic           push, full, pop, empty;
  sacl_pkg::req_t front_req, queue_req;

  sacl_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .in_data_i (s_axis_tdata),
    .push_o    (push),
    .req_o     (front_req),
    .full_i    (full)
  );

  sacl_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .req_i  (front_req),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .req_o  (queue_req)
  );

  sacl_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .req_i      (queue_req),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule

[dv/set_assoc_cache_tag_lru_test.sv]
// Self-checking testbench for the set-associative tag store with LRU replacement.
// Depends on sacl_pkg and the set_assoc_cache_tag_lru RTL; holds its own tag model.
`timescale 1ns / 1ps

module set_assoc_cache_tag_lru_test;

  typedef struct packed {
    logic [sacl_pkg::CntW-1:0]  dirty_ev;
    logic [sacl_pkg::CntW-1:0]  wr_miss;
    logic [sacl_pkg::CntW-1:0]  rd_miss;
    logic [sacl_pkg::CntW-1:0]  wr_acc;
    logic [sacl_pkg::CntW-1:0]  rd_acc;
    logic [sacl_pkg::CoreW-1:0] vic_core;
    logic [sacl_pkg::AddrW-1:0] vic_addr;
    logic                       vic_dirty;
    logic                       vic_valid;
    logic                       err;
    logic                       hit;
  } tag_result_t;

  localparam int NumLines = sacl_pkg::MaxSets * sacl_pkg::MaxWays;

  // Tag-store model plus the queue of predicted results
  class tag_scoreboard;
    logic [3:0]                  idx_bits;
    logic [3:0]                  ways_cfg;
    logic                        mode;
    logic                        v [NumLines];
    logic                        d [NumLines];
    logic [sacl_pkg::AddrW-1:0]  tg [NumLines];
    logic [sacl_pkg::CoreW-1:0]  own [NumLines];
    logic [sacl_pkg::StampW-1:0] stp [NumLines];
    logic                        rec_v, rec_d;
    logic [sacl_pkg::AddrW-1:0]  rec_addr;
    logic [sacl_pkg::CoreW-1:0]  rec_core;
    logic [sacl_pkg::CntW-1:0]   cnt [sacl_pkg::NumCnt];
    tag_result_t                 pending [$];
    int                          mismatches, hits, errors, checked;

    function new();
      idx_bits = 4'd8; ways_cfg = 4'd8; mode = 0;
      foreach (v[i]) begin
        v[i] = 0; d[i] = 0; tg[i] = 0; own[i] = 0; stp[i] = 0;
      end
      rec_v = 0; rec_d = 0; rec_addr = 0; rec_core = 0;
      foreach (cnt[i]) cnt[i] = 0;
      mismatches = 0; hits = 0; errors = 0; checked = 0;
    endfunction

    function void write_reg(sacl_pkg::cfg_idx_e idx, logic [3:0] val);
      case (idx)
        sacl_pkg::CfgSetBits: idx_bits = val;
        sacl_pkg::CfgWays:    ways_cfg = val;
        sacl_pkg::CfgMode:    mode = val[0];
        default: ;
      endcase
    endfunction

    function void bump(sacl_pkg::cnt_e k);
      if (cnt[k] != '1) cnt[k] = cnt[k] + 1;
    endfunction

    // Apply one accepted request and queue the resulting item
    function void note_request(logic [sacl_pkg::InDataW-1:0] td);
      sacl_pkg::func_e             fn;
      logic [sacl_pkg::AddrW-1:0]  addr, tag;
      logic                        wr, found;
      logic [sacl_pkg::CoreW-1:0]  core;
      logic [sacl_pkg::StampW-1:0] now, least;
      logic [63:0]                 set;
      int                          nways, base, vic, i;
      tag_result_t                 r;
      fn = sacl_pkg::func_e'(td[1:0]); addr = td[49:2]; wr = td[50];
      core = td[53:51]; now = td[101:54];
      set = ({16'd0, addr} & ((64'd1 << idx_bits) - 64'd1)) % sacl_pkg::MaxSets;
      tag = addr >> idx_bits;
      nways = (ways_cfg == 0) ? 1 :
              (ways_cfg > sacl_pkg::MaxWays) ? sacl_pkg::MaxWays : ways_cfg;
      base = int'(set) * sacl_pkg::MaxWays;
      r = '0;
      if (fn == sacl_pkg::FuncAccess) begin
        for (int w = 0; w < nways; w++) begin
          i = base + w;
          if (!r.hit && v[i] && tg[i] == tag && own[i] == core) begin
            r.hit = 1; stp[i] = now;
            if (wr) d[i] = 1;
          end
        end
        bump(wr ? sacl_pkg::CntWrAcc : sacl_pkg::CntRdAcc);
        if (!r.hit) bump(wr ? sacl_pkg::CntWrMiss : sacl_pkg::CntRdMiss);
      end else if (fn == sacl_pkg::FuncInstall) begin
        vic = 0; found = 1;
        if (!mode) begin
          least = now; found = 0;
          for (int w = 0; w < nways; w++)
            if (stp[base+w] < least) begin
              least = stp[base+w]; vic = w; found = 1;
            end
        end
        if (!found) r.err = 1;
        else begin
          i = base + vic;
          if (d[i]) bump(sacl_pkg::CntDirtyEv);
          rec_v = v[i]; rec_d = d[i]; rec_core = own[i];
          rec_addr = sacl_pkg::AddrW'(({16'd0, tg[i]} << idx_bits) | set);
          v[i] = 1; d[i] = wr; tg[i] = tag; own[i] = core; stp[i] = now;
        end
      end else if (fn == sacl_pkg::FuncClear) begin
        rec_v = 0; rec_d = 0;
      end
      r.vic_valid = rec_v; r.vic_dirty = rec_v & rec_d;
      r.vic_addr = rec_addr; r.vic_core = rec_core;
      r.rd_acc = cnt[sacl_pkg::CntRdAcc]; r.wr_acc = cnt[sacl_pkg::CntWrAcc];
      r.rd_miss = cnt[sacl_pkg::CntRdMiss]; r.wr_miss = cnt[sacl_pkg::CntWrMiss];
      r.dirty_ev = cnt[sacl_pkg::CntDirtyEv];
      hits += r.hit; errors += r.err;
      pending.push_back(r);
    endfunction

    function void check_result(logic [sacl_pkg::OutDataW-1:0] td);
      tag_result_t got, exp;
      got = td[$bits(tag_result_t)-1:0];
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp || td[sacl_pkg::OutDataW-1] !== 1'b0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: hit %b/%b err %b/%b vv %b/%b vd %b/%b va %h/%h vc %0d/%0d",
                   exp.hit, got.hit, exp.err, got.err, exp.vic_valid, got.vic_valid,
                   exp.vic_dirty, got.vic_dirty, exp.vic_addr, got.vic_addr,
                   exp.vic_core, got.vic_core);
        if (mismatches <= 10)
          $display("  counters exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                   exp.rd_acc, exp.wr_acc, exp.rd_miss, exp.wr_miss, exp.dirty_ev,
                   got.rd_acc, got.wr_acc, got.rd_miss, got.wr_miss, got.dirty_ev);
      end
    endfunction
  endclass

  localparam int WatchdogLimit = 20000;

  logic                          clk_i = 0, rst_ni = 0;
  logic                          cfg_we_i = 0;
  logic [1:0]                    cfg_idx_i = 0;
  logic [3:0]                    cfg_data_i = 0;
  logic                          s_axis_tvalid = 0, s_axis_tready;
  logic [sacl_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                          m_axis_tvalid, m_axis_tready = 0;
  logic [sacl_pkg::OutDataW-1:0] m_axis_tdata;

  tag_scoreboard sb = new();
  int  idle_cycles = 0;
  int  stall_mode = 0;
  int  items_sent = 0;
  logic [sacl_pkg::AddrW-1:0]  recent_addr [8];
  logic [2:0]                  recent_core [8];
  logic [sacl_pkg::StampW-1:0] clock_now = 48'd100;

  always #4 clk_i = ~clk_i;

  set_assoc_cache_tag_lru i_dut (.*);

  // Score both streams at the rising edge; watchdog on no progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WatchdogLimit) begin
        $display("set_assoc_cache_tag_lru test failed");
        $finish;
      end
    end
  end

  // Receiver stall pattern: phases of always-ready, random, and heavy stall
  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  task automatic send_item(sacl_pkg::func_e fn, logic [sacl_pkg::AddrW-1:0] addr,
                           logic wr, logic [sacl_pkg::CoreW-1:0] core,
                           logic [sacl_pkg::StampW-1:0] now);
    s_axis_tdata <= {2'b00, now, core, wr, addr, fn};
    s_axis_tvalid <= 1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic pause_sender();
    s_axis_tvalid <= 0;
    repeat ($urandom_range(1, 6)) @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  // One write cycle on the configuration port; the port is then idle until the task returns
  task automatic write_reg(sacl_pkg::cfg_idx_e idx, logic [3:0] val);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 0;
    sb.write_reg(idx, val);
    @(negedge clk_i);
  endtask

  // Random phase: mostly access/install on a small pool of recent lines
  task automatic random_phase(int n);
    sacl_pkg::func_e             fn;
    logic [sacl_pkg::AddrW-1:0]  addr;
    logic [sacl_pkg::CoreW-1:0]  core;
    logic [sacl_pkg::StampW-1:0] now;
    int k, burst;
    burst = $urandom_range(1, 12);
    for (int j = 0; j < n; j++) begin
      k = $urandom_range(0, 7);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: fn = sacl_pkg::FuncAccess;
        4, 5, 6, 7: fn = sacl_pkg::FuncInstall;
        8:          fn = sacl_pkg::FuncClear;
        default:    fn = sacl_pkg::FuncNone;
      endcase
      if ($urandom_range(0, 3) == 0) begin
        addr = sacl_pkg::AddrW'({$urandom, $urandom});
        core = 3'($urandom_range(0, 7));
        recent_addr[k] = addr; recent_core[k] = core;
      end else begin
        addr = recent_addr[k]; core = recent_core[k];
        if ($urandom_range(0, 7) == 0) core = 3'($urandom_range(0, 7));
      end
      clock_now = clock_now + sacl_pkg::StampW'($urandom_range(0, 3));
      now = clock_now;
      if ($urandom_range(0, 19) == 0) now = sacl_pkg::StampW'({$urandom, $urandom});
      send_item(fn, addr, 1'($urandom_range(0, 1)), core, now);
      if (--burst == 0) begin
        pause_sender();
        burst = $urandom_range(1, 12);
      end
    end
  endtask

  initial begin
    foreach (recent_addr[i]) begin
      recent_addr[i] = sacl_pkg::AddrW'({$urandom, $urandom});
      recent_core[i] = 3'($urandom_range(0, 7));
    end
    repeat (4) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed: field extremes, every func, tie and no-victim install
    send_item(sacl_pkg::FuncAccess, '1, 1, 3'd7, '1);
    send_item(sacl_pkg::FuncInstall, 48'h0000_0000_0012, 1, 3'd2, 48'd50);
    send_item(sacl_pkg::FuncAccess, 48'h0000_0000_0012, 0, 3'd2, 48'd60);
    send_item(sacl_pkg::FuncAccess, 48'h0000_0000_0012, 1, 3'd2, 48'd61);
    send_item(sacl_pkg::FuncAccess, 48'h0000_0000_0012, 0, 3'd5, 48'd62);
    send_item(sacl_pkg::FuncInstall, 48'h0000_0000_0112, 0, 3'd1, 48'd0);
    send_item(sacl_pkg::FuncInstall, 48'hFFFF_FFFF_FF12, 0, 3'd7, '1);
    for (int w = 0; w < 8; w++)
      send_item(sacl_pkg::FuncInstall, {40'(w + 1), 8'h12}, w[0], 3'(w), 48'd70);
    send_item(sacl_pkg::FuncInstall, 48'h0000_0000_0912, 1, 3'd0, 48'd70);
    send_item(sacl_pkg::FuncClear, '0, 0, 3'd0, '0);
    send_item(sacl_pkg::FuncNone, '1, 1, 3'd7, '1);
    send_item(sacl_pkg::FuncAccess, 48'h0000_0000_0012, 1, 3'd2, 48'd80);
    drain();

    // Configuration sweep, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(sacl_pkg::CfgSetBits, 4'd0); write_reg(sacl_pkg::CfgWays, 4'd1);
        end
        1: begin
          write_reg(sacl_pkg::CfgSetBits, 4'd15); write_reg(sacl_pkg::CfgWays, 4'd0);
        end
        2: begin
          write_reg(sacl_pkg::CfgSetBits, 4'd2); write_reg(sacl_pkg::CfgWays, 4'd15);
        end
        3: begin
          write_reg(sacl_pkg::CfgMode, 4'd1); write_reg(sacl_pkg::CfgSetBits, 4'd9);
        end
        4: begin
          write_reg(sacl_pkg::CfgMode, 4'd0); write_reg(sacl_pkg::CfgWays, 4'd3);
        end
        5: begin
          write_reg(sacl_pkg::CfgSetBits, 4'd1); write_reg(sacl_pkg::CfgWays, 4'd2);
        end
        6: begin
          write_reg(sacl_pkg::CfgUnused, 4'hF); write_reg(sacl_pkg::CfgMode, 4'd1);
        end
        default: begin
          write_reg(sacl_pkg::CfgMode, 4'd0); write_reg(sacl_pkg::CfgSetBits, 4'd8);
          write_reg(sacl_pkg::CfgWays, 4'd8);
        end
      endcase
      random_phase(55);
      drain();
    end

    $display("covered %0d items, %0d results checked, %0d hits, %0d install errors",
             items_sent, sb.checked, sb.hits, sb.errors);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("set_assoc_cache_tag_lru test passed");
    else
      $display("set_assoc_cache_tag_lru test failed");
    $finish;
  end

endmodule

[files.f]
rtl/sacl_pkg.sv
rtl/sacl_ram.sv
rtl/sacl_front.sv
rtl/sacl_queue.sv
rtl/sacl_back.sv
rtl/set_assoc_cache_tag_lru.sv
dv/set_assoc_cache_tag_lru_test.sv
